@@ rtl/core/mac_sighting_mru_table_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Sighting table assertion macros
// Shared concurrent assertion forms for the sighting table blocks.
// ----------------------------------------------------------------------------
`ifndef MAC_SIGHTING_MRU_TABLE_UNIT_ASSERT_SVH
`define MAC_SIGHTING_MRU_TABLE_UNIT_ASSERT_SVH

// Checked on every rising edge outside reset.
`define MSTU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MSTU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/mstu_pkg.sv @@
// ----------------------------------------------------------------------------
// Sighting table package
// Sizes, codes, state encoding and the command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package mstu_pkg;

    localparam int TABLE_DEPTH  = 16;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int FILL_W       = $clog2(TABLE_DEPTH + 1);
    localparam int RESULT_LIMIT = 16;
    localparam int REP_W        = 5;
    localparam int CMP_W        = (FILL_W > REP_W) ? FILL_W : REP_W;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_TOOCLOSE = 3'd2,
        ST_NONNEG   = 3'd3,
        ST_REPORT   = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        REG_MIN_GAP    = 2'd0,
        REG_SORT_KEY   = 2'd1,
        REG_MAX_REPORT = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        KEY_BEST = 2'd0,
        KEY_LAST = 2'd1,
        KEY_HITS = 2'd2
    } t_sort_key;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_HIT,
        S_MOVE,
        S_INSERT,
        S_EMIT_OBS,
        S_SCAN,
        S_EMIT_REP,
        S_EMIT_EMPTY
    } t_state;

    typedef struct packed {
        logic        [47:0] addr;
        logic signed [7:0]  last_str;
        logic signed [7:0]  best_str;
        logic        [31:0] last_time;
        logic        [31:0] best_time;
        logic        [7:0]  hits;
    } t_entry;

    typedef struct packed {
        logic    load;
        logic    search;
        logic    move;
        logic    insert;
        logic    scan;
        logic    emit;
        logic    report;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_mode;
        logic fill_zero;
        logic rep_none;
        logic match;
        logic cnt_last;
        logic too_close;
        logic nonneg;
        logic out_free;
        logic rep_last;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/core/mstu_obs_if.sv @@
// ----------------------------------------------------------------------------
// Sighting input channel
// Valid/ready channel carrying one observe or drain item per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mstu_obs_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic        [47:0] mac;
    logic signed [7:0]  rssi;
    logic        [31:0] obs_time;

    modport source (output valid, mode, mac, rssi, obs_time, input ready);
    modport sink   (input valid, mode, mac, rssi, obs_time, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mstu_res_if.sv @@
// ----------------------------------------------------------------------------
// Sighting result channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mstu_res_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  status;
    logic        [47:0] entry_addr;
    logic signed [7:0]  last_strength;
    logic signed [7:0]  best_strength;
    logic        [7:0]  hit_count;
    logic        [31:0] best_time;
    logic        [31:0] last_time;
    logic        [4:0]  table_fill;
    logic               last_of_run;

    modport source (output valid, status, entry_addr, last_strength, best_strength,
                    hit_count, best_time, last_time, table_fill, last_of_run,
                    input ready);
    modport sink   (input valid, status, entry_addr, last_strength, best_strength,
                    hit_count, best_time, last_time, table_fill, last_of_run,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/mstu_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Sighting configuration channel
// Register write channel: one register index and its data per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mstu_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] idx;
    logic [7:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mstu_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sighting table controller
// Sequences search, update, insertion, sorted report and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module mstu_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mstu_pkg::t_stat i_stat,
    output mstu_pkg::t_cmd     o_cmd,
    output logic               o_in_ready
);
    import mstu_pkg::*;

    t_state  r_state, n_state;
    t_status r_code,  n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_UPDATED;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        case (r_state)
            S_IDLE: begin
                if (i_stat.in_valid) begin
                    if (i_stat.in_mode) begin
                        n_state = i_stat.rep_none ? S_EMIT_EMPTY : S_SCAN;
                    end else begin
                        n_state = i_stat.fill_zero ? S_INSERT : S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (i_stat.match) begin
                    n_state = S_HIT;
                end else if (i_stat.cnt_last) begin
                    n_state = S_INSERT;
                end
            end
            S_HIT: begin
                if (i_stat.too_close) begin
                    n_code  = ST_TOOCLOSE;
                    n_state = S_EMIT_OBS;
                end else if (i_stat.nonneg) begin
                    n_code  = ST_NONNEG;
                    n_state = S_EMIT_OBS;
                end else begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                n_code  = ST_UPDATED;
                n_state = S_EMIT_OBS;
            end
            S_INSERT: begin
                n_code  = ST_INSERTED;
                n_state = S_EMIT_OBS;
            end
            S_EMIT_OBS: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_stat.cnt_last) begin
                    n_state = S_EMIT_REP;
                end
            end
            S_EMIT_REP: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.rep_last ? S_IDLE : S_SCAN;
                end
            end
            S_EMIT_EMPTY: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.code = r_code;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_stat.in_valid;
            end
            S_SEARCH: o_cmd.search = 1'b1;
            S_MOVE:   o_cmd.move   = 1'b1;
            S_INSERT: o_cmd.insert = 1'b1;
            S_EMIT_OBS: o_cmd.emit = i_stat.out_free;
            S_SCAN:   o_cmd.scan   = 1'b1;
            S_EMIT_REP: begin
                o_cmd.emit   = i_stat.out_free;
                o_cmd.report = 1'b1;
                o_cmd.code   = ST_REPORT;
            end
            S_EMIT_EMPTY: begin
                o_cmd.emit = i_stat.out_free;
                o_cmd.code = ST_EMPTY;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/mstu_dpath.sv @@
// ----------------------------------------------------------------------------
// Sighting table datapath
// Entry row with move-to-front shifting, the address scan, the sort key scan,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mac_sighting_mru_table_unit_assert.svh"

module mstu_dpath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mstu_pkg::t_cmd     i_cmd,
    output mstu_pkg::t_stat         o_stat,
    input  wire logic               i_in_valid,
    input  wire logic               i_mode,
    input  wire logic        [47:0] i_mac,
    input  wire logic signed [7:0]  i_rssi,
    input  wire logic        [31:0] i_obs_time,
    input  wire logic               i_cfg_valid,
    input  wire logic        [1:0]  i_cfg_idx,
    input  wire logic        [7:0]  i_cfg_data,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic             [2:0]  o_status,
    output logic             [47:0] o_entry_addr,
    output logic signed      [7:0]  o_last_strength,
    output logic signed      [7:0]  o_best_strength,
    output logic             [7:0]  o_hit_count,
    output logic             [31:0] o_best_time,
    output logic             [31:0] o_last_time,
    output logic             [4:0]  o_table_fill,
    output logic                    o_last_of_run
);
    import mstu_pkg::*;

    t_entry                r_tab [TABLE_DEPTH];
    logic [FILL_W-1:0]     r_fill;
    logic [FILL_W-1:0]     r_n;
    logic [47:0]           r_mac;
    logic signed [7:0]     r_rssi;
    logic [31:0]           r_time;
    logic [IDX_W-1:0]      r_cnt;
    logic [IDX_W-1:0]      r_sel;
    logic [TABLE_DEPTH-1:0] r_taken;
    logic                  r_have;
    logic signed [8:0]     r_best_key;
    logic [REP_W-1:0]      r_count;
    logic [REP_W-1:0]      r_emitted;
    logic [7:0]            r_min_gap;
    logic [1:0]            r_sort_key;
    logic [4:0]            r_max_report;

    t_entry                e_cur;
    t_entry                e_upd;
    t_entry                e_new;
    logic signed [8:0]     key;
    logic                  cand;
    logic [IDX_W-1:0]      best_idx;
    logic [CMP_W-1:0]      m1;
    logic [CMP_W-1:0]      m2;
    logic [31:0]           gap;
    logic                  out_free;

    // Single read pointer into the entry row.
    assign e_cur = r_tab[r_cnt];

    assign gap      = r_time - e_cur.last_time;
    assign out_free = !o_out_valid || i_out_ready;

    always_comb begin
        m1 = (CMP_W'(r_fill) < CMP_W'(r_max_report)) ? CMP_W'(r_fill) : CMP_W'(r_max_report);
        m2 = (m1 < CMP_W'(RESULT_LIMIT)) ? m1 : CMP_W'(RESULT_LIMIT);
    end

    always_comb begin
        case (r_sort_key)
            KEY_BEST: key = {e_cur.best_str[7], e_cur.best_str};
            KEY_LAST: key = {e_cur.last_str[7], e_cur.last_str};
            KEY_HITS: key = {1'b0, e_cur.hits};
            default:  key = '0;
        endcase
    end

    // Strict compare keeps the earlier entry on equal keys.
    assign cand     = !r_taken[r_cnt] && (!r_have || (key > r_best_key));
    assign best_idx = cand ? r_cnt : r_sel;

    always_comb begin
        e_upd           = e_cur;
        e_upd.last_str  = r_rssi;
        e_upd.last_time = r_time;
        e_upd.hits      = e_cur.hits + 8'd1;
        if (e_cur.best_str < r_rssi) begin
            e_upd.best_str  = r_rssi;
            e_upd.best_time = r_time;
        end
    end

    always_comb begin
        e_new.addr      = r_mac;
        e_new.last_str  = r_rssi;
        e_new.best_str  = r_rssi;
        e_new.last_time = r_time;
        e_new.best_time = r_time;
        e_new.hits      = 8'd1;
    end

    always_comb begin
        o_stat.in_valid  = i_in_valid;
        o_stat.in_mode   = i_mode;
        o_stat.fill_zero = (r_fill == '0);
        o_stat.rep_none  = (m2 == '0);
        o_stat.match     = (e_cur.addr == r_mac);
        o_stat.cnt_last  = (r_cnt == IDX_W'(r_n - FILL_W'(1)));
        o_stat.too_close = (gap < {24'd0, r_min_gap});
        o_stat.nonneg    = !r_rssi[7];
        o_stat.out_free  = out_free;
        o_stat.rep_last  = ((r_emitted + REP_W'(1)) == r_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.move) begin
            for (int j = 0; j < TABLE_DEPTH; j++) begin
                if (j == 0) begin
                    r_tab[j] <= e_upd;
                end else if (IDX_W'(j) <= r_cnt) begin
                    r_tab[j] <= r_tab[j-1];
                end
            end
        end else if (i_cmd.insert) begin
            for (int j = 0; j < TABLE_DEPTH; j++) begin
                if (j == 0) begin
                    r_tab[j] <= e_new;
                end else begin
                    r_tab[j] <= r_tab[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mac  <= i_mac;
            r_rssi <= i_rssi;
            r_time <= i_obs_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_n          <= '0;
            r_cnt        <= '0;
            r_sel        <= '0;
            r_taken      <= '0;
            r_have       <= 1'b0;
            r_best_key   <= '0;
            r_count      <= '0;
            r_emitted    <= '0;
            r_min_gap    <= 8'd5;
            r_sort_key   <= KEY_LAST;
            r_max_report <= 5'd5;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_idx)
                    REG_MIN_GAP:    r_min_gap    <= i_cfg_data;
                    REG_SORT_KEY:   r_sort_key   <= i_cfg_data[1:0];
                    REG_MAX_REPORT: r_max_report <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_n       <= r_fill;
                r_cnt     <= '0;
                r_have    <= 1'b0;
                r_taken   <= '0;
                r_emitted <= '0;
                r_count   <= REP_W'(m2);
                if (i_mode) begin
                    r_fill <= '0;
                end
            end
            if (i_cmd.search && !o_stat.match) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end
            if (i_cmd.move) begin
                r_cnt <= '0;
            end
            if (i_cmd.insert) begin
                r_cnt <= '0;
                if (r_n < FILL_W'(TABLE_DEPTH)) begin
                    r_n    <= r_n + FILL_W'(1);
                    r_fill <= r_n + FILL_W'(1);
                end
            end
            if (i_cmd.scan) begin
                r_sel <= best_idx;
                if (cand) begin
                    r_have     <= 1'b1;
                    r_best_key <= key;
                end
                // The winner's index becomes the read pointer for the beat.
                r_cnt <= o_stat.cnt_last ? best_idx : (r_cnt + IDX_W'(1));
            end
            if (i_cmd.emit && i_cmd.report) begin
                r_taken[r_cnt] <= 1'b1;
                r_emitted      <= r_emitted + REP_W'(1);
                r_cnt          <= '0;
                r_have         <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status     <= i_cmd.code;
            o_table_fill <= 5'(r_n);
            if (i_cmd.code == ST_EMPTY) begin
                o_entry_addr    <= '0;
                o_last_strength <= '0;
                o_best_strength <= '0;
                o_hit_count     <= '0;
                o_best_time     <= '0;
                o_last_time     <= '0;
            end else begin
                o_entry_addr    <= e_cur.addr;
                o_last_strength <= e_cur.last_str;
                o_best_strength <= e_cur.best_str;
                o_hit_count     <= e_cur.hits;
                o_best_time     <= e_cur.best_time;
                o_last_time     <= e_cur.last_time;
            end
            o_last_of_run <= i_cmd.report ? o_stat.rep_last : 1'b1;
        end
    end

    `MSTU_ASSERT(a_emit_free, i_clk, i_rst_n, i_cmd.emit |-> out_free, "result beat overwrites a waiting result")
    `MSTU_ASSERT(a_emit_count, i_clk, i_rst_n, r_emitted <= r_count, "more report beats than entries due")
    `MSTU_ASSERT(a_insert_fill, i_clk, i_rst_n, i_cmd.insert |=> (r_fill != '0), "insertion left the table empty")
    `MSTU_ASSERT(a_fill_max, i_clk, i_rst_n, r_fill <= FILL_W'(TABLE_DEPTH), "fill count beyond table depth")

endmodule

`default_nettype wire

@@ rtl/core/mac_sighting_mru_table_unit.sv @@
// ----------------------------------------------------------------------------
// Device sighting table with sorted report
// Keeps up to TABLE_DEPTH device sightings in most-recent-first order. An
// observe item scans the table one entry per clock for its address, using
// the single compare over the entry row, and its result beat may wait for
// the result channel. A drain item picks each reported entry by a full pass
// over the held entries, where the number reported is the smallest of the
// fill, max_report and 16. One item is worked on at a time, and the next is
// taken once its last result beat has been placed in the output register.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_sighting_mru_table_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mstu_obs_if.sink   i_obs,
    mstu_res_if.source o_res,
    mstu_cfg_if.sink   i_cfg
);
    import mstu_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_obs.ready = w_in_ready;
    assign i_cfg.ready = 1'b1;

    mstu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    mstu_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_in_valid      (i_obs.valid),
        .i_mode          (i_obs.mode),
        .i_mac           (i_obs.mac),
        .i_rssi          (i_obs.rssi),
        .i_obs_time      (i_obs.obs_time),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_idx       (i_cfg.idx),
        .i_cfg_data      (i_cfg.data),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_status        (o_res.status),
        .o_entry_addr    (o_res.entry_addr),
        .o_last_strength (o_res.last_strength),
        .o_best_strength (o_res.best_strength),
        .o_hit_count     (o_res.hit_count),
        .o_best_time     (o_res.best_time),
        .o_last_time     (o_res.last_time),
        .o_table_fill    (o_res.table_fill),
        .o_last_of_run   (o_res.last_of_run)
    );

endmodule

`default_nettype wire
